// File: rtl/spf_pkg.sv
// spf_pkg: types and constants shared by the servo packet framer modules
// no dependencies; used by spf_front, spf_queue, spf_back and the top level

package spf_pkg;

	// command item taken on the input channel
	typedef struct packed {
		logic        opcode;
		logic [7:0]  servo_id;
		logic [15:0] goal_position;
		logic [15:0] move_speed;
	} cmd_t;

	// one serial byte on the output channel
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       packet_end;
		logic       run_last;
	} tx_t;

	// configuration register file contents
	typedef struct packed {
		logic [4:0]  sync_entry_count;
		logic [15:0] sync_speed;
		logic [7:0]  write_opcode_byte;
		logic [7:0]  sync_opcode_byte;
		logic [7:0]  goal_address;
	} cfg_t;

	// classified work item passed from front to back
	typedef struct packed {
		logic        sync;       // 1 sync-write entry, 0 single write
		logic        hdr;        // sync entry opens a packet
		logic        chk;        // sync entry closes a packet
		logic [7:0]  sync_len;   // length byte of the sync packet
		logic [7:0]  servo_id;
		logic [15:0] goal_position;
		logic [15:0] move_speed;
	} work_t;

	// queue status toward the top level
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// opcodes
	localparam logic OP_SINGLE = 1'b0;
	localparam logic OP_SYNC   = 1'b1;

	// register indexes
	localparam logic [2:0] REG_SYNC_COUNT = 3'd0;
	localparam logic [2:0] REG_SYNC_SPEED = 3'd1;
	localparam logic [2:0] REG_WRITE_OP   = 3'd2;
	localparam logic [2:0] REG_SYNC_OP    = 3'd3;
	localparam logic [2:0] REG_GOAL_ADDR  = 3'd4;

	// register reset values
	localparam logic [4:0]  RST_SYNC_COUNT = 5'd1;
	localparam logic [15:0] RST_SYNC_SPEED = 16'd752;
	localparam logic [7:0]  RST_WRITE_OP   = 8'd3;
	localparam logic [7:0]  RST_SYNC_OP    = 8'd131;
	localparam logic [7:0]  RST_GOAL_ADDR  = 8'd30;

	// fixed packet bytes
	localparam logic [7:0] HDR_BYTE       = 8'hff;
	localparam logic [7:0] BCAST_ID       = 8'hfe;
	localparam logic [7:0] WRITE_LEN      = 8'h07;
	localparam logic [7:0] SYNC_ENTRY_LEN = 8'h04;
	localparam logic [7:0] SYNC_LEN_BASE  = 8'h04;

	// byte sequencer steps
	localparam logic [3:0] STEP_FIRST      = 4'd0;
	localparam logic [3:0] STEP_SUM_FIRST  = 4'd2;
	localparam logic [3:0] STEP_SINGLE_CHK = 4'd10;
	localparam logic [3:0] STEP_SYNC_ENTRY = 4'd7;
	localparam logic [3:0] STEP_SYNC_LAST  = 4'd11;
	localparam logic [3:0] STEP_SYNC_CHK   = 4'd12;

endpackage

// File: rtl/servo_command_packet_framer_core.sv
// servo_command_packet_framer_core: top level of the servo bus packet framer
// depends on spf_pkg, spf_front, spf_queue, spf_back; holds the APB register file
//
// channel   direction  handshake          payload
// cmd       in         cmd_valid/stall    spf_pkg::cmd_t (opcode, id, position, speed)
// tx        out        tx_valid/stall     spf_pkg::tx_t (tx_byte, packet_end, run_last)
// apb       in         psel/penable       5 registers at byte address 4*i
//
// one output beat per cycle while work is pending and tx is not stalled; an item is
// 11 bytes (single write) or 5, 6, 12 or 13 bytes (sync entry), set by the byte sequencer
// a two-entry queue lets command beats be taken back to back while bytes drain
// cmd_stall rises only while the queue is full; tx_stall holds the output register
// reset clears the registers to their defaults and the sync entry state

module servo_command_packet_framer_core #(
	parameter int MAX_ENTRIES = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spf_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output spf_pkg::tx_t  tx,
	output logic          tx_valid,
	input  logic          tx_stall,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	spf_pkg::cfg_t   cfg_q;
	spf_pkg::work_t  front_work;
	spf_pkg::work_t  q_data;
	spf_pkg::qstat_t q_stat;
	logic            take;
	logic            q_pop;
	logic            wr_en;
	logic [2:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_entry_count  <= spf_pkg::RST_SYNC_COUNT;
			cfg_q.sync_speed        <= spf_pkg::RST_SYNC_SPEED;
			cfg_q.write_opcode_byte <= spf_pkg::RST_WRITE_OP;
			cfg_q.sync_opcode_byte  <= spf_pkg::RST_SYNC_OP;
			cfg_q.goal_address      <= spf_pkg::RST_GOAL_ADDR;
		end else if (wr_en) begin
			case (reg_idx)
				spf_pkg::REG_SYNC_COUNT: cfg_q.sync_entry_count  <= pwdata[4:0];
				spf_pkg::REG_SYNC_SPEED: cfg_q.sync_speed        <= pwdata[15:0];
				spf_pkg::REG_WRITE_OP:   cfg_q.write_opcode_byte <= pwdata[7:0];
				spf_pkg::REG_SYNC_OP:    cfg_q.sync_opcode_byte  <= pwdata[7:0];
				spf_pkg::REG_GOAL_ADDR:  cfg_q.goal_address      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			spf_pkg::REG_SYNC_COUNT: prdata = {27'd0, cfg_q.sync_entry_count};
			spf_pkg::REG_SYNC_SPEED: prdata = {16'd0, cfg_q.sync_speed};
			spf_pkg::REG_WRITE_OP:   prdata = {24'd0, cfg_q.write_opcode_byte};
			spf_pkg::REG_SYNC_OP:    prdata = {24'd0, cfg_q.sync_opcode_byte};
			spf_pkg::REG_GOAL_ADDR:  prdata = {24'd0, cfg_q.goal_address};
			default:                 prdata = 32'd0;
		endcase
	end

	// input handshake
	assign cmd_stall = q_stat.full;
	assign take      = cmd_valid && !cmd_stall;

	spf_front #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.take   (take),
		.work   (front_work)
	);

	spf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (front_work),
		.pop       (q_pop),
		.pop_data  (q_data),
		.stat      (q_stat)
	);

	spf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_avail  (!q_stat.empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.tx       (tx),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall)
	);

	// a checksum byte always closes the bytes of its command
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx.packet_end |-> tx.run_last)
		else $error("checksum beat not marked as last");

	// the queue is never full and empty at once
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// a beat taken into an empty queue leaves it non-empty next cycle
	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		take && q_stat.empty |=> !q_stat.empty)
		else $error("accepted command lost by the queue");

endmodule

// File: rtl/spf_front.sv
// spf_front: accepts command beats and classifies sync entries
// depends on spf_pkg; tracks the entry count of the pending sync packet

module spf_front #(
	parameter int MAX_ENTRIES = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spf_pkg::cfg_t  cfg,
	input  spf_pkg::cmd_t  cmd,
	input  logic           take,
	output spf_pkg::work_t work
);

	logic [4:0] entries_sent_q;
	logic [7:0] cnt_raw;
	logic [7:0] cnt_max;
	logic [7:0] cnt_eff;
	logic [7:0] sent_next;
	logic       sync_last;

	// effective entry count, clamped to one and to the maximum
	always_comb begin
		cnt_raw = {3'b000, cfg.sync_entry_count};
		cnt_max = 8'(MAX_ENTRIES);
		if (cnt_raw == 8'd0) begin
			cnt_eff = 8'd1;
		end else if (cnt_raw > cnt_max) begin
			cnt_eff = cnt_max;
		end else begin
			cnt_eff = cnt_raw;
		end
		sent_next = {3'b000, entries_sent_q} + 8'd1;
		sync_last = (sent_next >= cnt_eff);
	end

	// classification of the incoming beat
	always_comb begin
		work.sync          = (cmd.opcode == spf_pkg::OP_SYNC);
		work.hdr           = (entries_sent_q == 5'd0);
		work.chk           = sync_last;
		work.sync_len      = {cnt_eff[5:0], 2'b00} + cnt_eff + spf_pkg::SYNC_LEN_BASE;
		work.servo_id      = cmd.servo_id;
		work.goal_position = cmd.goal_position;
		work.move_speed    = cmd.move_speed;
	end

	// entries already sent in the pending sync packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_sent_q <= 5'd0;
		end else if (take) begin
			if (cmd.opcode == spf_pkg::OP_SINGLE || sync_last) begin
				entries_sent_q <= 5'd0;
			end else begin
				entries_sent_q <= sent_next[4:0];
			end
		end
	end

endmodule

// File: rtl/spf_queue.sv
// spf_queue: two-entry queue of classified work items
// depends on spf_pkg; sits between the front and the back

module spf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  spf_pkg::work_t   push_data,
	input  logic             pop,
	output spf_pkg::work_t   pop_data,
	output spf_pkg::qstat_t  stat
);

	spf_pkg::work_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/spf_back.sv
// spf_back: byte sequencer that emits packet bytes and the checksum
// depends on spf_pkg; pops work items from spf_queue, drives the output register

module spf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  spf_pkg::cfg_t   cfg,
	input  logic            q_avail,
	input  spf_pkg::work_t  q_data,
	output logic            q_pop,
	output spf_pkg::tx_t    tx,
	output logic            tx_valid,
	input  logic            tx_stall
);

	spf_pkg::work_t item_q;
	logic           busy_q;
	logic [3:0]     step_q;
	logic [7:0]     sum_q;
	spf_pkg::tx_t   tx_q;
	logic           tx_valid_q;

	logic           adv;
	logic           emit;
	logic           at_last;
	logic           at_chk;
	logic           sum_en;
	logic [3:0]     last_step;
	logic [3:0]     start_step;
	logic [7:0]     byte_val;

	assign tx       = tx_q;
	assign tx_valid = tx_valid_q;

	// output register can take a byte
	assign adv  = !tx_valid_q || !tx_stall;
	assign emit = busy_q && adv;

	// step bounds of the current item
	always_comb begin
		if (!item_q.sync) begin
			last_step = spf_pkg::STEP_SINGLE_CHK;
		end else if (item_q.chk) begin
			last_step = spf_pkg::STEP_SYNC_CHK;
		end else begin
			last_step = spf_pkg::STEP_SYNC_LAST;
		end
		at_last = (step_q == last_step);
		at_chk  = at_last && (!item_q.sync || item_q.chk);
		sum_en  = (step_q >= spf_pkg::STEP_SUM_FIRST) && !at_chk;
	end

	// first step of the next item
	always_comb begin
		if (q_data.sync && !q_data.hdr) begin
			start_step = spf_pkg::STEP_SYNC_ENTRY;
		end else begin
			start_step = spf_pkg::STEP_FIRST;
		end
	end

	// byte selection
	always_comb begin
		if (!item_q.sync) begin
			case (step_q)
				4'd0, 4'd1: byte_val = spf_pkg::HDR_BYTE;
				4'd2:       byte_val = item_q.servo_id;
				4'd3:       byte_val = spf_pkg::WRITE_LEN;
				4'd4:       byte_val = cfg.write_opcode_byte;
				4'd5:       byte_val = cfg.goal_address;
				4'd6:       byte_val = item_q.goal_position[7:0];
				4'd7:       byte_val = item_q.goal_position[15:8];
				4'd8:       byte_val = item_q.move_speed[7:0];
				4'd9:       byte_val = item_q.move_speed[15:8];
				default:    byte_val = ~sum_q;
			endcase
		end else begin
			case (step_q)
				4'd0, 4'd1: byte_val = spf_pkg::HDR_BYTE;
				4'd2:       byte_val = spf_pkg::BCAST_ID;
				4'd3:       byte_val = item_q.sync_len;
				4'd4:       byte_val = cfg.sync_opcode_byte;
				4'd5:       byte_val = cfg.goal_address;
				4'd6:       byte_val = spf_pkg::SYNC_ENTRY_LEN;
				4'd7:       byte_val = item_q.servo_id;
				4'd8:       byte_val = item_q.goal_position[7:0];
				4'd9:       byte_val = item_q.goal_position[15:8];
				4'd10:      byte_val = cfg.sync_speed[7:0];
				4'd11:      byte_val = cfg.sync_speed[15:8];
				default:    byte_val = ~sum_q;
			endcase
		end
	end

	// pop when idle or when the last byte of the current item leaves
	assign q_pop = q_avail && (!busy_q || (emit && at_last));

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= spf_pkg::STEP_FIRST;
			tx_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				tx_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= start_step;
			end else if (emit) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// item, running checksum and output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_data;
		end
		if (emit) begin
			sum_q           <= ((step_q == spf_pkg::STEP_FIRST) ? 8'd0 : sum_q)
				+ (sum_en ? byte_val : 8'd0);
			tx_q.tx_byte    <= byte_val;
			tx_q.packet_end <= at_chk;
			tx_q.run_last   <= at_last;
		end
	end

endmodule

// File: dv/servo_command_packet_framer_core_tb.sv
// servo_command_packet_framer_core_tb: self-checking testbench for the servo packet framer
// depends on spf_pkg and servo_command_packet_framer_core; predicts every serial byte,
// checks each output beat against it and checks register read-back over apb

module servo_command_packet_framer_core_tb;

	localparam int MAX_ENTRIES = 24;
	localparam int CHUNK_ITEMS = 45;

	logic          clk;
	logic          arst_n;
	spf_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_stall;
	spf_pkg::tx_t  tx;
	logic          tx_valid;
	logic          tx_stall;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [4:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	// register copy and sync packet state of the predictor
	spf_pkg::cfg_t reg_shadow;
	logic [4:0]    sync_done;
	logic [7:0]    sync_sum;

	spf_pkg::tx_t pending_bytes[$];
	spf_pkg::tx_t head_beat;
	int           mismatch_count = 0;
	int           snd_idle_pct;
	int           rcv_stall_pct;

	servo_command_packet_framer_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.tx       (tx),
		.tx_valid (tx_valid),
		.tx_stall (tx_stall),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		tx_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// compare each accepted output beat with the oldest predicted byte
	always @(posedge clk) begin
		if (tx_valid === 1'b1 && tx_stall == 1'b0) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: beat expected none got %h", $time, tx);
				mismatch_count++;
			end else begin
				head_beat = pending_bytes.pop_front();
				check_field("tx_byte", 32'(head_beat.tx_byte), 32'(tx.tx_byte));
				check_field("packet_end", 32'(head_beat.packet_end), 32'(tx.packet_end));
				check_field("run_last", 32'(head_beat.run_last), 32'(tx.run_last));
			end
		end
	end

	function automatic int entries_per_packet();
		int n;
		n = int'(reg_shadow.sync_entry_count);
		if (n < 1)
			n = 1;
		if (n > MAX_ENTRIES)
			n = MAX_ENTRIES;
		return n;
	endfunction

	function automatic spf_pkg::cmd_t make_cmd(input logic op, input logic [7:0] id,
			input logic [15:0] pos, input logic [15:0] spd);
		spf_pkg::cmd_t c;
		c.opcode        = op;
		c.servo_id      = id;
		c.goal_position = pos;
		c.move_speed    = spd;
		return c;
	endfunction

	function automatic spf_pkg::cmd_t random_cmd(input logic op);
		return make_cmd(op, 8'($urandom_range(255)), 16'($urandom), 16'($urandom));
	endfunction

	// work out the serial bytes one command causes and queue them
	task automatic frame_bytes(input spf_pkg::cmd_t c);
		logic [8:0]   seq[$];
		logic [7:0]   body[$];
		logic [7:0]   sum;
		logic [7:0]   len;
		logic         opens;
		logic         closes;
		int           cnt;
		spf_pkg::tx_t beat;
		if (c.opcode == spf_pkg::OP_SINGLE) begin
			opens  = 1'b1;
			closes = 1'b1;
			sum    = '0;
			body.push_back(c.servo_id);
			body.push_back(spf_pkg::WRITE_LEN);
			body.push_back(reg_shadow.write_opcode_byte);
			body.push_back(reg_shadow.goal_address);
			body.push_back(c.goal_position[7:0]);
			body.push_back(c.goal_position[15:8]);
			body.push_back(c.move_speed[7:0]);
			body.push_back(c.move_speed[15:8]);
		end else begin
			cnt    = entries_per_packet();
			opens  = (sync_done == 0);
			closes = (int'(sync_done) + 1 >= cnt);
			sum    = opens ? 8'h00 : sync_sum;
			if (opens) begin
				len = 8'(5 * cnt) + spf_pkg::SYNC_LEN_BASE;
				body.push_back(spf_pkg::BCAST_ID);
				body.push_back(len);
				body.push_back(reg_shadow.sync_opcode_byte);
				body.push_back(reg_shadow.goal_address);
				body.push_back(spf_pkg::SYNC_ENTRY_LEN);
			end
			body.push_back(c.servo_id);
			body.push_back(c.goal_position[7:0]);
			body.push_back(c.goal_position[15:8]);
			body.push_back(reg_shadow.sync_speed[7:0]);
			body.push_back(reg_shadow.sync_speed[15:8]);
		end
		if (opens) begin
			seq.push_back({spf_pkg::HDR_BYTE, 1'b0});
			seq.push_back({spf_pkg::HDR_BYTE, 1'b0});
		end
		foreach (body[i]) begin
			sum = sum + body[i];
			seq.push_back({body[i], 1'b0});
		end
		if (closes)
			seq.push_back({~sum, 1'b1});
		// a single move drops any open sync packet
		if (closes) begin
			sync_done = '0;
			sync_sum  = '0;
		end else begin
			sync_done = sync_done + 5'd1;
			sync_sum  = sum;
		end
		foreach (seq[i]) begin
			beat.tx_byte    = seq[i][8:1];
			beat.packet_end = seq[i][0];
			beat.run_last   = (i == seq.size() - 1);
			pending_bytes.push_back(beat);
		end
	endtask

	// one command beat, with idle cycles in front
	task automatic send_cmd(input spf_pkg::cmd_t c);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		frame_bytes(c);
	endtask

	// stop sending and let every predicted byte drain
	task automatic settle();
		cmd_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic [2:0] idx);
		logic [31:0] rdata;
		logic [31:0] want;
		apb_access(1'b0, idx, '0, rdata);
		case (idx)
			spf_pkg::REG_SYNC_COUNT: want = 32'(reg_shadow.sync_entry_count);
			spf_pkg::REG_SYNC_SPEED: want = 32'(reg_shadow.sync_speed);
			spf_pkg::REG_WRITE_OP:   want = 32'(reg_shadow.write_opcode_byte);
			spf_pkg::REG_SYNC_OP:    want = 32'(reg_shadow.sync_opcode_byte);
			default:                 want = 32'(reg_shadow.goal_address);
		endcase
		check_field("register read", want, rdata);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] rdata;
		apb_access(1'b1, idx, val, rdata);
		case (idx)
			spf_pkg::REG_SYNC_COUNT: reg_shadow.sync_entry_count  = val[4:0];
			spf_pkg::REG_SYNC_SPEED: reg_shadow.sync_speed        = val[15:0];
			spf_pkg::REG_WRITE_OP:   reg_shadow.write_opcode_byte = val[7:0];
			spf_pkg::REG_SYNC_OP:    reg_shadow.sync_opcode_byte  = val[7:0];
			default:                 reg_shadow.goal_address      = val[7:0];
		endcase
		check_reg(idx);
	endtask

	// reset register values, then id and field extremes with one-entry sync packets
	task automatic test_defaults();
		check_reg(spf_pkg::REG_SYNC_COUNT);
		check_reg(spf_pkg::REG_SYNC_SPEED);
		check_reg(spf_pkg::REG_WRITE_OP);
		check_reg(spf_pkg::REG_SYNC_OP);
		check_reg(spf_pkg::REG_GOAL_ADDR);
		send_cmd(make_cmd(spf_pkg::OP_SINGLE, 8'd0, 16'h0000, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SINGLE, 8'd255, 16'hffff, 16'hffff));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd254, 16'h0000, 16'hffff));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd0, 16'hffff, 16'h0000));
		settle();
	endtask

	// sync count at zero, which acts as one; every other register at its low and high end
	task automatic test_register_extremes();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd0);
		set_reg(spf_pkg::REG_SYNC_SPEED, 32'hffff);
		set_reg(spf_pkg::REG_WRITE_OP, 32'hff);
		set_reg(spf_pkg::REG_SYNC_OP, 32'h00);
		set_reg(spf_pkg::REG_GOAL_ADDR, 32'hff);
		send_cmd(make_cmd(spf_pkg::OP_SINGLE, 8'd253, 16'h8001, 16'h7ffe));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd255, 16'hffff, 16'h1234));
		settle();
		set_reg(spf_pkg::REG_SYNC_SPEED, 32'h0000);
		set_reg(spf_pkg::REG_WRITE_OP, 32'h00);
		set_reg(spf_pkg::REG_SYNC_OP, 32'hff);
		set_reg(spf_pkg::REG_GOAL_ADDR, 32'h00);
		send_cmd(make_cmd(spf_pkg::OP_SINGLE, 8'd1, 16'h00ff, 16'hff00));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd128, 16'h5aa5, 16'hffff));
		settle();
	endtask

	// counts above the maximum clamp; a plain two-entry packet
	task automatic test_entry_count_clamp();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd25);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd10, 16'h0102, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd11, 16'h0304, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SINGLE, 8'd12, 16'h0506, 16'h0708));
		settle();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd31);
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd2);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd20, 16'hfedc, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd21, 16'hba98, 16'h0000));
		settle();
	endtask

	// count rewritten between entries of an open packet
	task automatic test_count_change_mid_sync();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd4);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd30, 16'h1111, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd31, 16'h2222, 16'h0000));
		settle();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd2);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd32, 16'h3333, 16'h0000));
		settle();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd3);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd33, 16'h4444, 16'h0000));
		settle();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd5);
		set_reg(spf_pkg::REG_SYNC_SPEED, 32'h0a0b);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd34, 16'h5555, 16'h0000));
		settle();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd1);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd35, 16'h6666, 16'h0000));
		settle();
	endtask

	// a single move abandons the open sync packet, the next entry opens a new one
	task automatic test_single_abandons_sync();
		set_reg(spf_pkg::REG_SYNC_COUNT, 32'd3);
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd40, 16'hc0de, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SINGLE, 8'd41, 16'h0bad, 16'hbeef));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd42, 16'h1357, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd43, 16'h2468, 16'h0000));
		send_cmd(make_cmd(spf_pkg::OP_SYNC, 8'd44, 16'h9abc, 16'h0000));
		settle();
	endtask

	// all registers random; counts mostly small, sometimes zero or at and past the top
	task automatic shuffle_config();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			set_reg(spf_pkg::REG_SYNC_COUNT, 32'd0);
		else if (pick < 22)
			set_reg(spf_pkg::REG_SYNC_COUNT, 32'($urandom_range(20, 31)));
		else
			set_reg(spf_pkg::REG_SYNC_COUNT, 32'($urandom_range(1, 6)));
		set_reg(spf_pkg::REG_SYNC_SPEED, 32'($urandom_range(65535)));
		set_reg(spf_pkg::REG_WRITE_OP, 32'($urandom_range(255)));
		set_reg(spf_pkg::REG_SYNC_OP, 32'($urandom_range(255)));
		set_reg(spf_pkg::REG_GOAL_ADDR, 32'($urandom_range(255)));
	endtask

	// mostly whole sync packets, some cut short, some single moves in between
	task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
			input int chunks);
		int sent;
		int run_len;
		int pick;
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		repeat (chunks) begin
			shuffle_config();
			sent = 0;
			while (sent < CHUNK_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 20) begin
					send_cmd(random_cmd(spf_pkg::OP_SINGLE));
					sent++;
				end else begin
					run_len = entries_per_packet();
					if (pick < 35)
						run_len = $urandom_range(1, run_len);
					repeat (run_len) send_cmd(random_cmd(spf_pkg::OP_SYNC));
					sent += run_len;
				end
			end
			settle();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cmd       <= '0;
		cmd_valid <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		reg_shadow = '{sync_entry_count: spf_pkg::RST_SYNC_COUNT,
			sync_speed: spf_pkg::RST_SYNC_SPEED,
			write_opcode_byte: spf_pkg::RST_WRITE_OP,
			sync_opcode_byte: spf_pkg::RST_SYNC_OP,
			goal_address: spf_pkg::RST_GOAL_ADDR};
		sync_done     = '0;
		sync_sum      = '0;
		snd_idle_pct  = 8;
		rcv_stall_pct = 68;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_register_extremes();
		test_entry_count_clamp();
		test_count_change_mid_sync();
		test_single_abandons_sync();
		test_random_traffic(8, 68, 3);
		test_random_traffic(68, 8, 3);
		test_random_traffic(0, 0, 3);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
